// ===== src/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the half quarter-round function for the
// ChaCha20 byte-stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

	// "expand 32-byte k" as four little-endian words
	localparam logic [31:0] SIGMA [4] = '{
		32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
	};

	localparam int NUM_WORDS = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_0_1   = 3'd0,
		REG_KEY_2_3   = 3'd1,
		REG_KEY_4_5   = 3'd2,
		REG_KEY_6_7   = 3'd3,
		REG_NONCE_0_1 = 3'd4,
		REG_NONCE_2   = 3'd5,
		REG_INIT_CTR  = 3'd6
	} cfg_reg_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // latch word, set up working words and counter
		logic round;      // run one half quarter-round step on all four lanes
		logic diag;       // diagonal lanes instead of columns
		logic second;     // second half of the quarter-round (rotate 8 and 7)
		logic finish;     // add input words back, bump the block counter
		logic emit_in;    // output the incoming word xor keystream
		logic emit_hold;  // output the held word xor keystream
	} cmd_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} qr_t;

	// half of a quarter-round: two add, xor, rotate steps
	function automatic qr_t half_qr(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d, input logic second);
		qr_t r;
		logic [31:0] x;
		logic [31:0] y;
		r.a = a + b;
		x = d ^ r.a;
		r.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
		r.c = c + r.d;
		y = b ^ r.c;
		r.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/chacha20_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 (96-bit nonce, 32-bit counter) byte-stream cipher: each input
// word is xored with the next keystream byte.
//
// channel   dir   signals                     content
// s_*       in    s_tvalid s_tready           tdata: data_byte, tuser: start_req
// m_*       out   m_tvalid m_tready           tdata: out_byte
// cfg_*     in    cfg_we cfg_index cfg_data   key, nonce, initial counter
//
// a word that lands inside an existing keystream block is xored with the stored block;
// the first word of a block waits for a new block of DOUBLE_ROUNDS double rounds:
// one half quarter-round step per cycle on four lanes, then final add
// single output register: while a result waits for m_tready, s_tready stays low
// reset clears counter and position, so a first message without start_req starts at block 0
// ----------------------------------------------------------------------------
`default_nettype none

module chacha20_stream_cipher_top #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]                       s_tuser,   // [0] start_req
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [7:0]                            m_tdata,   // [7:0] out_byte
	input  wire logic                             cfg_we,
	input  wire logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cc20_pkg::*;

	cmd_t cmd;
	logic need_block;

	// sequencer
	cc20_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.need_block (need_block),
		.cmd        (cmd)
	);

	// block function and keystream
	cc20_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_start   (s_tuser[0]),
		.in_byte    (s_tdata),
		.cmd        (cmd),
		.need_block (need_block),
		.out_byte   (m_tdata)
	);

endmodule

`default_nettype wire

// ===== src/cc20_core.sv =====
// ----------------------------------------------------------------------------
// cc20_core
// Datapath: configuration registers, working words, keystream block,
// block counter, byte position and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_start,
	input  wire logic [7:0]                       in_byte,
	input  wire cc20_pkg::cmd_t                   cmd,
	output logic                                  need_block,
	output logic [7:0]                            out_byte
);
	import cc20_pkg::*;

	logic [63:0] key_q [4];
	logic [63:0] nonce01_q;
	logic [31:0] nonce2_q;
	logic [31:0] init_ctr_q;

	logic [31:0] work_q [NUM_WORDS];
	logic [31:0] ks_q   [NUM_WORDS];
	logic [31:0] blk_ctr_q;
	logic [5:0]  pos_q;
	logic [7:0]  byte_q;
	logic [7:0]  out_byte_q;

	logic [31:0] ctr_sel;
	logic [31:0] init_w [NUM_WORDS];
	logic [31:0] work_d [NUM_WORDS];
	logic [3:0]  bi [4];
	logic [3:0]  ci [4];
	logic [3:0]  di [4];
	qr_t         qr [4];
	logic [32*NUM_WORDS-1:0] ks_flat;
	logic [7:0]  ks_byte;

	// configuration writes, out-of-range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce01_q  <= '0;
			nonce2_q   <= '0;
			init_ctr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_0_1:   key_q[0]   <= cfg_data;
				REG_KEY_2_3:   key_q[1]   <= cfg_data;
				REG_KEY_4_5:   key_q[2]   <= cfg_data;
				REG_KEY_6_7:   key_q[3]   <= cfg_data;
				REG_NONCE_0_1: nonce01_q  <= cfg_data;
				REG_NONCE_2:   nonce2_q   <= cfg_data[31:0];
				REG_INIT_CTR:  init_ctr_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// block input words
	assign ctr_sel = (cmd.load && in_start) ? init_ctr_q : blk_ctr_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = SIGMA[i];
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = ctr_sel;
		init_w[13] = nonce01_q[31:0];
		init_w[14] = nonce01_q[63:32];
		init_w[15] = nonce2_q;
	end

	// lane word selection, columns or diagonals
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bi[i] = cmd.diag ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
			ci[i] = cmd.diag ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
			di[i] = cmd.diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
		end
	end

	// four independent half quarter-rounds
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qr[i] = half_qr(work_q[i], work_q[bi[i]], work_q[ci[i]], work_q[di[i]],
				cmd.second);
		end
		work_d = work_q;
		for (int i = 0; i < 4; i++) begin
			work_d[i]     = qr[i].a;
			work_d[bi[i]] = qr[i].b;
			work_d[ci[i]] = qr[i].c;
			work_d[di[i]] = qr[i].d;
		end
	end

	// working words and keystream block
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= init_w;
			byte_q <= in_byte;
		end else if (cmd.round) begin
			work_q <= work_d;
		end
		if (cmd.finish) begin
			for (int i = 0; i < NUM_WORDS; i++) ks_q[i] <= work_q[i] + init_w[i];
		end
	end

	// block counter and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_ctr_q <= '0;
			pos_q     <= '0;
		end else begin
			if (cmd.load) begin
				blk_ctr_q <= ctr_sel;
				pos_q     <= '0;
			end else if (cmd.emit_in || cmd.emit_hold) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.finish) blk_ctr_q <= blk_ctr_q + 32'd1;
		end
	end

	// keystream byte at the current position, little-endian
	always_comb begin
		for (int i = 0; i < NUM_WORDS; i++) ks_flat[32*i +: 32] = ks_q[i];
	end
	assign ks_byte = ks_flat[{pos_q, 3'b000} +: 8];

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit_in) out_byte_q <= in_byte ^ ks_byte;
		else if (cmd.emit_hold) out_byte_q <= byte_q ^ ks_byte;
	end

	assign need_block = in_start || (pos_q == 6'd0);
	assign out_byte   = out_byte_q;

endmodule

`default_nettype wire

// ===== src/cc20_ctrl.sv =====
// ----------------------------------------------------------------------------
// cc20_ctrl
// Controller: handshakes, round step counter and the block sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_ctrl #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	input  wire logic       need_block,
	output cc20_pkg::cmd_t  cmd
);
	import cc20_pkg::*;

	localparam int STEPS = 4 * DOUBLE_ROUNDS;
	localparam int SW    = $clog2(STEPS);

	state_t        state_q;
	state_t        state_d;
	logic [SW-1:0] step_q;
	logic [SW-1:0] step_d;
	logic          out_valid_q;
	logic          accept;

	// input ready only when idle and the output register is free or draining
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= cmd.emit_in || cmd.emit_hold || (out_valid_q && !m_tready);
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (need_block) begin
						cmd.load = 1'b1;
						step_d   = '0;
						state_d  = ST_ROUND;
					end else begin
						cmd.emit_in = 1'b1;
					end
				end
			end
			ST_ROUND: begin
				cmd.round  = 1'b1;
				cmd.diag   = step_q[1];
				cmd.second = step_q[0];
				step_d     = step_q + SW'(1);
				if (step_q == SW'(STEPS - 1)) state_d = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.finish = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_hold = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

	// no new word taken while a block is being made
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready)
		else $error("input ready while block generation is running");

	// the held result always finds an empty output register
	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !out_valid_q)
		else $error("output register busy when block result is emitted");

	// block setup starts the round sequence from step zero
	a_load_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_ROUND && step_q == '0)
		else $error("round sequence did not start after load");

	// finishing a block is followed by its result
	a_finish_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> cmd.emit_hold)
		else $error("block finished without emitting its word");

endmodule

`default_nettype wire
